// ===== rtl/core/frdb_pkg.sv =====
// ----------------------------------------------------------------------------
// frdb_pkg
// Shared types, constants and tables for the FIR response-in-dB block.
// ----------------------------------------------------------------------------
package frdb_pkg;

    // Sizes of the tap store and the point range
    localparam int MAX_TAPS   = 128;
    localparam int MAX_POINTS = 4096;
    localparam int TAP_AW     = $clog2(MAX_TAPS);
    localparam int TAP_CW     = $clog2(MAX_TAPS + 1);
    localparam int NPT_W      = $clog2(MAX_POINTS + 1);

    // Field widths
    localparam int TAP_W      = 16;
    localparam int TIDX_W     = 7;
    localparam int POINT_W    = 12;
    localparam int DB_OUT_W   = 16;
    localparam int NTAPS_W    = 8;
    localparam int NPTS_W     = 13;

    // Configuration port
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_TAPS   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_NUM_POINTS = CFG_IDX_W'(1);
    localparam int NUM_TAPS_RST   = 23;
    localparam int NUM_POINTS_RST = 512;

    // Arithmetic
    localparam int PHASE_W      = 32;
    localparam int DIV_STEPS    = POINT_W + PHASE_W - 1;
    localparam int CORDIC_STEPS = 28;
    localparam int CORDIC_W     = 34;
    localparam int CORDIC_START = 652032874;
    localparam int PROD_W       = TAP_W + CORDIC_W;
    localparam int ACC_W        = PROD_W + TAP_AW + 1;
    localparam int RND_SHIFT    = 24;
    localparam int MAG_W        = 30;
    localparam int SQ_W         = 2 * MAG_W;
    localparam int MSQ_W        = SQ_W + 1;
    localparam int NORM_W       = 64;
    localparam int EXP_W        = 6;
    localparam int MANT_W       = 31;
    localparam int LOG_BITS     = 16;
    localparam int LX_W         = EXP_W + LOG_BITS + 1;
    localparam int LOG_OFFSET   = 40;
    localparam int DB_SCALE_Q32 = 50504453;
    localparam int V_W          = 50;
    localparam int DB_W         = V_W - 32;
    localparam int SMALL_LIMIT  = 109;
    localparam int DB_FLOOR     = -25600;
    localparam int DB_CEIL      = 16383;
    localparam int CNT_W        = 6;

    typedef struct packed {
        logic                       action;
        logic [TIDX_W-1:0]          tap_index;
        logic signed [TAP_W-1:0]    tap_value;
        logic [POINT_W-1:0]         point_index;
    } in_item_t;

    typedef struct packed {
        logic [POINT_W-1:0]         point_echo;
        logic signed [DB_OUT_W-1:0] magnitude_db;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_TAP_INIT,
        ST_CORDIC,
        ST_MUL,
        ST_ACC,
        ST_ROUND,
        ST_SQ_RE,
        ST_SQ_IM,
        ST_SUM,
        ST_NORM,
        ST_LOG_MUL,
        ST_LOG_CHK,
        ST_SCALE,
        ST_FINAL,
        ST_DONE
    } frdb_state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic              load;
        logic              start;
        logic              div_step;
        logic              tap_init;
        logic              cordic_step;
        logic              mul;
        logic              acc;
        logic              round;
        logic              sq_re;
        logic              sq_im;
        logic              sum;
        logic              norm_shift;
        logic              log_init;
        logic              log_mul;
        logic              log_chk;
        logic              scale;
        logic              final_db;
        logic              out_load;
        logic [CNT_W-1:0]  step;
        logic [TAP_AW-1:0] tap_addr;
    } frdb_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic [TAP_CW-1:0] taps;
        logic              small_mag;
        logic              norm_top;
        logic              out_free;
    } frdb_status_t;

    // arctan(2^-i) in units of 2^-32 turn
    function automatic logic [29:0] atan_turn(input logic [4:0] i);
        logic [29:0] r;
        case (i)
            5'd0:    r = 30'd536870912;
            5'd1:    r = 30'd316933406;
            5'd2:    r = 30'd167458907;
            5'd3:    r = 30'd85004756;
            5'd4:    r = 30'd42667331;
            5'd5:    r = 30'd21354465;
            5'd6:    r = 30'd10679838;
            5'd7:    r = 30'd5340245;
            5'd8:    r = 30'd2670163;
            5'd9:    r = 30'd1335087;
            5'd10:   r = 30'd667544;
            5'd11:   r = 30'd333772;
            5'd12:   r = 30'd166886;
            5'd13:   r = 30'd83443;
            5'd14:   r = 30'd41722;
            5'd15:   r = 30'd20861;
            5'd16:   r = 30'd10430;
            5'd17:   r = 30'd5215;
            5'd18:   r = 30'd2608;
            5'd19:   r = 30'd1304;
            5'd20:   r = 30'd652;
            5'd21:   r = 30'd326;
            5'd22:   r = 30'd163;
            5'd23:   r = 30'd81;
            5'd24:   r = 30'd41;
            5'd25:   r = 30'd20;
            5'd26:   r = 30'd10;
            5'd27:   r = 30'd5;
            default: r = 30'd0;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/core/frdb_ram.sv =====
// ----------------------------------------------------------------------------
// frdb_ram
// Simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module frdb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/core/frdb_ctrl.sv =====
// ----------------------------------------------------------------------------
// frdb_ctrl
// Sequencer: walks division, the per-tap CORDIC loop, squaring and log.
// ----------------------------------------------------------------------------
module frdb_ctrl import frdb_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    input  logic         in_action,
    output logic         in_ready,
    input  frdb_status_t status,
    output frdb_cmd_t    cmd
);

    frdb_state_t       state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [TAP_CW-1:0] tap_reg, tap_next;
    logic [TAP_CW-1:0] tap_inc;

    assign tap_inc = tap_reg + TAP_CW'(1);

    // state and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            tap_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            tap_reg   <= tap_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        tap_next     = tap_reg;
        in_ready     = 1'b0;
        cmd          = '0;
        cmd.step     = cnt_reg;
        cmd.tap_addr = tap_reg[TAP_AW-1:0];
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_action)
                    begin
                        cmd.start  = 1'b1;
                        cnt_next   = '0;
                        state_next = ST_DIV;
                    end
                    else
                    begin
                        cmd.load = 1'b1;
                    end
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    cnt_next   = '0;
                    tap_next   = '0;
                    state_next = (status.taps == '0) ? ST_ROUND : ST_TAP_INIT;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_TAP_INIT:
            begin
                cmd.tap_init = 1'b1;
                cnt_next     = '0;
                state_next   = ST_CORDIC;
            end
            ST_CORDIC:
            begin
                cmd.cordic_step = 1'b1;
                if (cnt_reg == CNT_W'(CORDIC_STEPS - 1))
                begin
                    state_next = ST_MUL;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                cmd.acc    = 1'b1;
                tap_next   = tap_inc;
                state_next = (tap_inc == status.taps) ? ST_ROUND : ST_TAP_INIT;
            end
            ST_ROUND:
            begin
                cmd.round  = 1'b1;
                state_next = ST_SQ_RE;
            end
            ST_SQ_RE:
            begin
                cmd.sq_re  = 1'b1;
                state_next = ST_SQ_IM;
            end
            ST_SQ_IM:
            begin
                cmd.sq_im  = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = ST_NORM;
            end
            ST_NORM:
            begin
                if (status.small_mag)
                begin
                    state_next = ST_FINAL;
                end
                else if (status.norm_top)
                begin
                    cmd.log_init = 1'b1;
                    cnt_next     = CNT_W'(LOG_BITS - 1);
                    state_next   = ST_LOG_MUL;
                end
                else
                begin
                    cmd.norm_shift = 1'b1;
                end
            end
            ST_LOG_MUL:
            begin
                cmd.log_mul = 1'b1;
                state_next  = ST_LOG_CHK;
            end
            ST_LOG_CHK:
            begin
                cmd.log_chk = 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = ST_SCALE;
                end
                else
                begin
                    cnt_next   = cnt_reg - CNT_W'(1);
                    state_next = ST_LOG_MUL;
                end
            end
            ST_SCALE:
            begin
                cmd.scale  = 1'b1;
                state_next = ST_FINAL;
            end
            ST_FINAL:
            begin
                cmd.final_db = 1'b1;
                state_next   = ST_DONE;
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/frdb_datapath.sv =====
// ----------------------------------------------------------------------------
// frdb_datapath
// Tap store, config registers, phase divider, CORDIC, accumulators,
// squaring, log2 and dB scaling, plus the output word register.
// ----------------------------------------------------------------------------
module frdb_datapath import frdb_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  frdb_cmd_t             cmd,
    output frdb_status_t          status,
    input  in_item_t              in_data,
    input  logic                  cfg_valid,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_item_t             out_data
);

    // configuration and output control
    logic [NTAPS_W-1:0] num_taps_reg;
    logic [NPTS_W-1:0]  num_points_reg;
    logic               out_valid_reg;
    out_item_t          out_data_reg;

    // tap store
    logic                    tap_we;
    logic [TAP_W-1:0]        tap_rdata;
    logic signed [TAP_W-1:0] tap_s;

    // effective sizes
    logic [TAP_CW-1:0] taps_eff;
    logic [NPT_W-1:0]  n_eff;

    // phase generation
    logic [POINT_W-1:0] point_reg;
    logic [NPT_W-1:0]   n_reg;
    logic [POINT_W-1:0] dvd_reg;
    logic [NPT_W-1:0]   rem_reg;
    logic [PHASE_W-1:0] quo_reg;
    logic [PHASE_W-1:0] phase_reg;
    logic [NPT_W-1:0]   pfrac_reg;
    logic [NPT_W:0]     rem_sh;
    logic               rem_ge;
    logic [NPT_W:0]     pfrac_sum;
    logic               pfrac_ge;

    // CORDIC
    logic [1:0]                 quad;
    logic [PHASE_W-1:0]         ru;
    logic [1:0]                 quad_reg;
    logic signed [CORDIC_W-1:0] x_reg, y_reg, z_reg;
    logic signed [CORDIC_W-1:0] xs, ys, at;
    logic signed [CORDIC_W-1:0] cos_v, sin_v;

    // accumulate and magnitude
    logic signed [PROD_W-1:0]   prod_re_reg, prod_im_reg;
    logic signed [ACC_W-1:0]    acc_re_reg, acc_im_reg;
    logic signed [ACC_W-1:0]    rnd_re, rnd_im;
    logic signed [CORDIC_W-1:0] re_s, im_s, re_n, im_n;
    logic [MAG_W-1:0]           ar_reg, ai_reg;
    logic [SQ_W-1:0]            sq_re_reg, sq_im_reg;
    logic [MSQ_W-1:0]           msq;
    logic                       small_reg;

    // log2 and dB
    logic [NORM_W-1:0]        norm_reg;
    logic [EXP_W-1:0]         exp_reg;
    logic [MANT_W-1:0]        mant_reg;
    logic [2*MANT_W-1:0]      lp_reg;
    logic [MANT_W:0]          lt;
    logic [LOG_BITS-1:0]      frac_reg;
    logic signed [LX_W-1:0]   lx;
    logic signed [V_W-1:0]    v_reg;
    logic signed [V_W-1:0]    v_pos, v_neg;
    logic signed [DB_W-1:0]   db_wide;
    logic signed [DB_OUT_W-1:0] res_reg;

    assign tap_we = cmd.load && (32'(in_data.tap_index) < MAX_TAPS);
    assign tap_s  = signed'(tap_rdata);

    frdb_ram #(
        .WIDTH(TAP_W),
        .DEPTH(MAX_TAPS)
    ) u_tap_ram (
        .clk   (clk),
        .we    (tap_we),
        .waddr (TAP_AW'(in_data.tap_index)),
        .wdata (in_data.tap_value),
        .raddr (cmd.tap_addr),
        .rdata (tap_rdata)
    );

    // clamp the register settings to the supported range
    always_comb
    begin
        if (32'(num_taps_reg) > MAX_TAPS)
            taps_eff = TAP_CW'(MAX_TAPS);
        else
            taps_eff = TAP_CW'(num_taps_reg);
        if (num_points_reg == '0)
            n_eff = NPT_W'(1);
        else if (32'(num_points_reg) > MAX_POINTS)
            n_eff = NPT_W'(MAX_POINTS);
        else
            n_eff = NPT_W'(num_points_reg);
    end

    // restoring division step and phase remainder carry
    assign rem_sh    = {rem_reg, dvd_reg[POINT_W-1]};
    assign rem_ge    = rem_sh >= {1'b0, n_reg};
    assign pfrac_sum = {1'b0, pfrac_reg} + {1'b0, rem_reg};
    assign pfrac_ge  = pfrac_sum >= {1'b0, n_reg};

    // quadrant split of the phase
    assign quad = 2'((phase_reg + 32'h2000_0000) >> 30);
    assign ru   = phase_reg - {quad, 30'b0};

    // CORDIC shifts and angle
    assign xs = x_reg >>> cmd.step;
    assign ys = y_reg >>> cmd.step;
    assign at = signed'(CORDIC_W'(atan_turn(cmd.step[4:0])));

    // quadrant correction
    always_comb
    begin
        case (quad_reg)
            2'd0:
            begin
                cos_v = x_reg;
                sin_v = y_reg;
            end
            2'd1:
            begin
                cos_v = -y_reg;
                sin_v = x_reg;
            end
            2'd2:
            begin
                cos_v = -x_reg;
                sin_v = -y_reg;
            end
            default:
            begin
                cos_v = y_reg;
                sin_v = -x_reg;
            end
        endcase
    end

    // round the sums to Q.20 and take magnitudes
    assign rnd_re = acc_re_reg + (ACC_W'(1) <<< (RND_SHIFT - 1));
    assign rnd_im = acc_im_reg + (ACC_W'(1) <<< (RND_SHIFT - 1));
    assign re_s   = rnd_re[ACC_W-1:RND_SHIFT];
    assign im_s   = rnd_im[ACC_W-1:RND_SHIFT];
    assign re_n   = re_s[CORDIC_W-1] ? -re_s : re_s;
    assign im_n   = im_s[CORDIC_W-1] ? -im_s : im_s;
    assign msq    = MSQ_W'(sq_re_reg) + MSQ_W'(sq_im_reg);

    // log2 squaring result and dB rounding
    assign lt      = lp_reg[2*MANT_W-1:MANT_W-1];
    assign lx      = signed'({1'b0, exp_reg, frac_reg}) - LX_W'(LOG_OFFSET * 65536);
    assign v_pos   = v_reg + (V_W'(1) <<< 31);
    assign v_neg   = -v_reg + (V_W'(1) <<< 31);
    assign db_wide = v_reg[V_W-1] ? -signed'(v_neg[V_W-1:32]) : signed'(v_pos[V_W-1:32]);

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_taps_reg   <= NTAPS_W'(NUM_TAPS_RST);
            num_points_reg <= NPTS_W'(NUM_POINTS_RST);
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_index == REG_NUM_TAPS)
                num_taps_reg <= cfg_data[NTAPS_W-1:0];
            if (cfg_valid && cfg_index == REG_NUM_POINTS)
                num_points_reg <= cfg_data[NPTS_W-1:0];
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            point_reg  <= in_data.point_index;
            dvd_reg    <= in_data.point_index;
            n_reg      <= n_eff;
            rem_reg    <= '0;
            quo_reg    <= '0;
            phase_reg  <= '0;
            pfrac_reg  <= '0;
            acc_re_reg <= '0;
            acc_im_reg <= '0;
        end
        if (cmd.div_step)
        begin
            dvd_reg <= {dvd_reg[POINT_W-2:0], 1'b0};
            rem_reg <= rem_ge ? NPT_W'(rem_sh - {1'b0, n_reg}) : NPT_W'(rem_sh);
            quo_reg <= {quo_reg[PHASE_W-2:0], rem_ge};
        end
        if (cmd.tap_init)
        begin
            quad_reg <= quad;
            x_reg    <= CORDIC_W'(CORDIC_START);
            y_reg    <= '0;
            z_reg    <= CORDIC_W'(signed'(ru));
        end
        if (cmd.cordic_step)
        begin
            if (!z_reg[CORDIC_W-1])
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - at;
            end
            else
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + at;
            end
        end
        if (cmd.mul)
        begin
            prod_re_reg <= PROD_W'(tap_s) * PROD_W'(cos_v);
            prod_im_reg <= PROD_W'(tap_s) * PROD_W'(sin_v);
        end
        if (cmd.acc)
        begin
            acc_re_reg <= acc_re_reg + ACC_W'(prod_re_reg);
            acc_im_reg <= acc_im_reg + ACC_W'(prod_im_reg);
            // next phase: quotient plus carried remainder, wraps mod one turn
            if (pfrac_ge)
            begin
                pfrac_reg <= NPT_W'(pfrac_sum - {1'b0, n_reg});
                phase_reg <= phase_reg + quo_reg + PHASE_W'(1);
            end
            else
            begin
                pfrac_reg <= NPT_W'(pfrac_sum);
                phase_reg <= phase_reg + quo_reg;
            end
        end
        if (cmd.round)
        begin
            ar_reg <= re_n[MAG_W-1:0];
            ai_reg <= im_n[MAG_W-1:0];
        end
        if (cmd.sq_re)
            sq_re_reg <= SQ_W'(ar_reg) * SQ_W'(ar_reg);
        if (cmd.sq_im)
            sq_im_reg <= SQ_W'(ai_reg) * SQ_W'(ai_reg);
        if (cmd.sum)
        begin
            norm_reg  <= NORM_W'(msq);
            exp_reg   <= EXP_W'(NORM_W - 1);
            small_reg <= msq <= MSQ_W'(SMALL_LIMIT);
        end
        if (cmd.norm_shift)
        begin
            norm_reg <= {norm_reg[NORM_W-2:0], 1'b0};
            exp_reg  <= exp_reg - EXP_W'(1);
        end
        if (cmd.log_init)
        begin
            mant_reg <= norm_reg[NORM_W-1:NORM_W-MANT_W];
            frac_reg <= '0;
        end
        if (cmd.log_mul)
            lp_reg <= (2*MANT_W)'(mant_reg) * (2*MANT_W)'(mant_reg);
        if (cmd.log_chk)
        begin
            if (lt[MANT_W])
            begin
                mant_reg                <= lt[MANT_W:1];
                frac_reg[cmd.step[3:0]] <= 1'b1;
            end
            else
            begin
                mant_reg <= lt[MANT_W-1:0];
            end
        end
        if (cmd.scale)
            v_reg <= V_W'(lx) * V_W'(DB_SCALE_Q32);
        if (cmd.final_db)
        begin
            if (small_reg || db_wide < DB_W'(DB_FLOOR))
                res_reg <= DB_OUT_W'(DB_FLOOR);
            else if (db_wide > DB_W'(DB_CEIL))
                res_reg <= DB_OUT_W'(DB_CEIL);
            else
                res_reg <= db_wide[DB_OUT_W-1:0];
        end
        if (cmd.out_load)
        begin
            out_data_reg.point_echo   <= point_reg;
            out_data_reg.magnitude_db <= res_reg;
        end
    end

    assign status.taps      = taps_eff;
    assign status.small_mag = small_reg;
    assign status.norm_top  = norm_reg[NORM_W-1];
    assign status.out_free  = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== rtl/core/fir_frequency_response_db.sv =====
// ----------------------------------------------------------------------------
// fir_frequency_response_db
// FIR tap store with magnitude response in 1/256 dB at one frequency point.
// ----------------------------------------------------------------------------
//  channel | signals                            | word
//  --------+------------------------------------+-------------------------
//  in      | in_valid, in_ready, in_data        | load tap / evaluate point
//  out     | out_valid, out_ready, out_data     | point echo and dB value
//  cfg     | cfg_valid, cfg_ready, cfg_index,   | num_taps, num_points
//          | cfg_data                           |
//
//  A load word is taken while idle, and the input stays ready. An evaluate word
//  runs a 43-step phase divider, then one 28-step CORDIC pass, multiply and
//  accumulate per tap, then a bit-per-cycle normalise of the 64-bit squared
//  magnitude and a 16-step log2; a magnitude below the -100 dB floor skips the
//  normalise and the log2.
//  A finished result waits in the output register; new words are taken
//  meanwhile, and the next result stalls until that register is free.
//  Reset idles the controller and presets config; the tap store is not cleared.
//  Config is accepted in every cycle.
// ----------------------------------------------------------------------------
module fir_frequency_response_db import frdb_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_item_t              in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_item_t             out_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    frdb_cmd_t    cmd;
    frdb_status_t status;

    assign cfg_ready = 1'b1;

    frdb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_action (in_data.action),
        .in_ready  (in_ready),
        .status    (status),
        .cmd       (cmd)
    );

    frdb_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_data   (in_data),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

// ===== rtl/core/frdb_checker.sv =====
// ----------------------------------------------------------------------------
// frdb_checker
// Port-level checks for the FIR response block, bound to the top level.
// ----------------------------------------------------------------------------
module frdb_checker import frdb_pkg::*; (
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input in_item_t  in_data,
    input logic      out_valid,
    input logic      out_ready,
    input out_item_t out_data
);

    // a waiting result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result word changed while stalled");

    // result stays within the dB range
    a_db_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.magnitude_db >= DB_OUT_W'(DB_FLOOR)
                       && out_data.magnitude_db <= DB_OUT_W'(DB_CEIL)))
        else $error("magnitude out of range");

    // an evaluate word makes the block busy
    a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_data.action |=> !in_ready)
        else $error("input taken during evaluation");

    // a load word leaves the input ready
    a_load_quick: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !in_data.action |=> in_ready)
        else $error("load stalled the input");

    // a new result only appears at the end of an evaluation
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared while idle");

endmodule

bind fir_frequency_response_db frdb_checker u_frdb_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

// ===== verif/tb_fir_frequency_response_db.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fir_frequency_response_db
// Self-checking bench for the FIR response-in-dB block: loads taps, evaluates
// points under several num_taps / num_points settings, and checks every
// result word against a bit-exact fixed-point predictor of the response.
// ----------------------------------------------------------------------------
module tb_fir_frequency_response_db;
    import frdb_pkg::*;

    localparam int IDLE_LIMIT = 30000;

    typedef enum logic { ACT_LOAD = 1'b0, ACT_EVAL = 1'b1 } action_e;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    in_item_t              in_data = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    out_item_t             out_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Predictor state
    logic signed [TAP_W-1:0] tap_copy [MAX_TAPS];
    int unsigned             taps_setting = NUM_TAPS_RST;
    int unsigned             points_setting = NUM_POINTS_RST;
    out_item_t               pending_db [$];
    int                      error_count = 0;
    int                      burst_left = 0;
    int                      idle_cycles = 0;

    longint atan_step [CORDIC_STEPS] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5
    };

    fir_frequency_response_db uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    // cos/sin in Q1.30 of a 32-bit turn fraction
    task automatic rotate_phase(input logic [31:0] turn, output longint c, output longint s);
        logic [31:0] quad;
        logic [31:0] rem;
        longint x, y, z, xs, ys;
        quad = ((turn + 32'h2000_0000) >> 30) & 32'd3;
        rem  = turn - (quad << 30);
        z = longint'($signed(rem));
        x = CORDIC_START;
        y = 0;
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0)
            begin
                x -= ys; y += xs; z -= atan_step[i];
            end
            else
            begin
                x += ys; y -= xs; z += atan_step[i];
            end
        end
        case (quad)
            32'd0:   begin c = x;  s = y;  end
            32'd1:   begin c = -y; s = x;  end
            32'd2:   begin c = -x; s = -y; end
            default: begin c = y;  s = -x; end
        endcase
    endtask

    // log2 in Q16, truncated
    function automatic longint log2_fixed(input longint unsigned v);
        int e;
        longint unsigned y;
        longint r;
        e = 63;
        while (v[e] == 1'b0)
            e--;
        y = (e >= 30) ? (v >> (e - 30)) : (v << (30 - e));
        r = longint'(e) * 65536;
        for (int i = 15; i >= 0; i--)
        begin
            y = (y * y) >> 30;
            if (y >= (64'd1 << 31))
            begin
                y >>= 1;
                r += longint'(1) << i;
            end
        end
        return r;
    endfunction

    // Magnitude response in 1/256 dB at one point
    task automatic predict_db(input int unsigned pt, output logic signed [15:0] db_out);
        int unsigned     ntap;
        longint unsigned n, m;
        logic [31:0]     turn;
        longint          re, im, c, s, x, v, db;
        longint unsigned ar, ai, msq;
        ntap = (taps_setting > MAX_TAPS) ? MAX_TAPS : taps_setting;
        n = (points_setting == 0) ? 1 :
            ((points_setting > MAX_POINTS) ? MAX_POINTS : points_setting);
        re = 0;
        im = 0;
        for (int unsigned j = 0; j < ntap; j++)
        begin
            m = (longint'(pt) * j) % (2 * n);
            turn = 32'((m << 31) / n);
            rotate_phase(turn, c, s);
            re += longint'(tap_copy[j]) * c;
            im += longint'(tap_copy[j]) * s;
        end
        re = (re + (longint'(1) << 23)) >>> 24;
        im = (im + (longint'(1) << 23)) >>> 24;
        ar = (re < 0) ? -re : re;
        ai = (im < 0) ? -im : im;
        msq = ar * ar + ai * ai;
        if (msq <= SMALL_LIMIT)
            db = DB_FLOOR;
        else
        begin
            x = log2_fixed(msq) - longint'(LOG_OFFSET) * 65536;
            v = x * DB_SCALE_Q32;
            if (v >= 0)
                db = (v + (longint'(1) << 31)) >>> 32;
            else
                db = -((-v + (longint'(1) << 31)) >>> 32);
            if (db < DB_FLOOR) db = DB_FLOOR;
            if (db > DB_CEIL)  db = DB_CEIL;
        end
        db_out = 16'(db);
    endtask

    // Send one word with burst/gap pacing, predict on acceptance
    task automatic send_word(input in_item_t w);
        out_item_t exp_w;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data  <= w;
        do @(posedge clk); while (!in_ready);
        if (w.action == ACT_LOAD)
            tap_copy[w.tap_index] = w.tap_value;
        else
        begin
            exp_w.point_echo = w.point_index;
            predict_db(w.point_index, exp_w.magnitude_db);
            pending_db.push_back(exp_w);
        end
    endtask

    task automatic load_tap(input int idx, input int val);
        in_item_t w;
        w.action      = ACT_LOAD;
        w.tap_index   = TIDX_W'(idx);
        w.tap_value   = TAP_W'(val);
        w.point_index = POINT_W'($urandom);
        send_word(w);
    endtask

    task automatic eval_point(input int pt);
        in_item_t w;
        w.action      = ACT_EVAL;
        w.tap_index   = TIDX_W'($urandom);
        w.tap_value   = TAP_W'($urandom);
        w.point_index = POINT_W'(pt);
        send_word(w);
    endtask

    // Register write, only once the block has drained
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_db.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_NUM_TAPS)
            taps_setting = val & 16'h00FF;
        else if (idx == REG_NUM_POINTS)
            points_setting = val & 16'h1FFF;
    endtask

    // Result checker
    always @(posedge clk)
    begin
        out_item_t exp_w;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_db.size() == 0)
            begin
                $display("%0t: unexpected word point=%0d db=%0d", $time,
                         out_data.point_echo, out_data.magnitude_db);
                error_count++;
            end
            else
            begin
                exp_w = pending_db.pop_front();
                if (out_data.point_echo !== exp_w.point_echo)
                begin
                    $display("%0t: point_echo expected %0d actual %0d", $time,
                             exp_w.point_echo, out_data.point_echo);
                    error_count++;
                end
                if (out_data.magnitude_db !== exp_w.magnitude_db)
                begin
                    $display("%0t: magnitude_db expected %0d actual %0d (point %0d)", $time,
                             exp_w.magnitude_db, out_data.magnitude_db, exp_w.point_echo);
                    error_count++;
                end
            end
        end
    end

    // Receiver stall pattern: a random mode is drawn each time stall_cnt[5:0] is zero
    int unsigned stall_mode = 0;
    int unsigned stall_cnt = 0;
    always @(posedge clk)
    begin
        if (stall_cnt[5:0] == 6'd0)
            stall_mode <= $urandom_range(0, 3);
        stall_cnt <= stall_cnt + 1;
        case (stall_mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= ($urandom_range(0, 3) != 0);
            2:       out_ready <= (stall_cnt[4:0] > 5'd24);
            default: out_ready <= $urandom_range(0, 1);
        endcase
    end

    // Watchdog on cycles without any accepted word
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Fill the store so no unwritten tap is ever read
    task automatic test_tap_fill();
        for (int i = 0; i < MAX_TAPS; i++)
            load_tap(i, -32768);
    endtask

    task automatic test_directed();
        write_reg(REG_NUM_TAPS, 16'd128);
        eval_point(0);
        eval_point(4095);
        // more than the store holds: clamps to all taps
        write_reg(REG_NUM_TAPS, 16'hFFFF);
        eval_point(1);
        write_reg(REG_NUM_TAPS, 16'd4);
        for (int i = 0; i < 4; i++)
            load_tap(i, 0);
        eval_point(0);          // all-zero taps: floor
        load_tap(0, 32767);
        load_tap(127, 32767);
        eval_point(7);
        // empty sum
        write_reg(REG_NUM_TAPS, 16'd0);
        eval_point(100);
        write_reg(REG_NUM_TAPS, 16'd3);
        write_reg(REG_NUM_POINTS, 16'd0);
        eval_point(1);
        eval_point(4095);       // past the last point: phase wraps
        write_reg(REG_NUM_POINTS, 16'h1FFF);
        eval_point(4095);
        eval_point(2048);
        // unknown register index leaves settings alone
        write_reg(CFG_IDX_W'(2), 16'h0001);
        write_reg(CFG_IDX_W'(15), 16'hFFFF);
        eval_point(3);
        write_reg(REG_NUM_POINTS, 16'd1);
        eval_point(4095);
    endtask

    task automatic test_random_traffic();
        int taps_plan [8]  = '{1, 7, 23, 40, 2, 0, 16, 200};
        int items_plan [8] = '{200, 200, 200, 150, 200, 100, 230, 20};
        int pts_pick;
        logic [15:0] pts_val;
        for (int p = 0; p < 8; p++)
        begin
            write_reg(REG_NUM_TAPS, {8'($urandom), 8'(taps_plan[p])});
            pts_pick = $urandom_range(0, 5);
            case (pts_pick)
                0:       pts_val = 16'd1;
                1:       pts_val = 16'd4096;
                2:       pts_val = 16'd0;
                3:       pts_val = 16'h1FFF;
                default: pts_val = 16'($urandom_range(2, 4095));
            endcase
            write_reg(REG_NUM_POINTS, {3'($urandom), pts_val[12:0]});
            for (int k = 0; k < items_plan[p]; k++)
            begin
                if ($urandom_range(0, 9) < 4)
                    load_tap($urandom_range(0, MAX_TAPS - 1), int'(16'($urandom)));
                else if ($urandom_range(0, 7) == 0)
                    eval_point($urandom_range(0, 1) ? 0 : 4095);
                else
                    eval_point($urandom_range(0, 4095));
            end
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_tap_fill();
        test_directed();
        test_random_traffic();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_db.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
